>>> rtl/crse_pkg.sv
// crse_pkg: shared types and constants for the Catmull-Rom spline evaluator.
// No dependencies; imported by crse_blend and catmull_rom_spline_evaluator.
`default_nettype none

package crse_pkg;

	localparam int COORD_W   = 32;             // Q16.16 coordinate
	localparam int POINT_W   = 3 * COORD_W;    // packed {z, y, x} table word
	localparam int CNT_REG_W = 7;              // point_count register width
	localparam int MIN_POINTS = 4;             // fewer points give a null result

	// Catmull-Rom coefficients reach 12 * 2^31 in magnitude
	localparam int COEF_W = COORD_W + 4;
	// a + three weighted terms, before the final halving
	localparam int SUM_W  = COORD_W + 6;

	typedef logic signed [COORD_W-1:0] coord_t;

	localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_EVAL  = 1'b1;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
		logic   ok;
	} res_t;

endpackage

`default_nettype wire

>>> rtl/catmull_rom_spline_evaluator.sv
// catmull_rom_spline_evaluator: top level, index pipeline, point tables, output skid.
// Depends on crse_pkg, crse_ram and crse_blend.
`default_nettype none

// Uniform Catmull-Rom evaluator over a table of up to MAX_POINTS 3-D control
// points in signed Q16.16. A command beat with opcode write stores one point
// (slots at or above MAX_POINTS are dropped, no result beat). A command beat
// with opcode eval takes t in unsigned Q1.T_FRAC_BITS (values above 1.0 are
// treated as 1.0) and returns one result beat: the curve point, saturated to
// 32 bits, with result_valid set when point_count is at least four
// (otherwise all fields are zero). The datapath is a straight eight-stage
// pipeline and takes one beat every cycle while cmd_stall is low, writes and
// evals mixed freely; the four control points per eval come from two copies
// of the table, each with two read ports, so reads never contend. A result
// beat that is stalled parks in the output register, one more lands in a
// skid register, and only then does cmd_stall rise. point_count is sampled
// at command entry and may change only when the block is idle. Slots never
// written read back as garbage.
module catmull_rom_spline_evaluator
	import crse_pkg::*;
#(
	parameter int MAX_POINTS  = 64,
	parameter int T_FRAC_BITS = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// configuration: point_count
	input  wire logic                 cfg_we,
	input  wire logic [CNT_REG_W-1:0] cfg_wdata,
	// command channel
	input  wire logic                 cmd_valid,
	output logic                      cmd_stall,
	input  wire logic                 opcode,
	input  wire logic [5:0]           point_index,
	input  wire coord_t               point_x,
	input  wire coord_t               point_y,
	input  wire coord_t               point_z,
	input  wire logic [T_FRAC_BITS:0] t_param,
	// result channel
	output logic                      rsp_valid,
	input  wire logic                 rsp_stall,
	output coord_t                    curve_x,
	output coord_t                    curve_y,
	output coord_t                    curve_z,
	output logic                      result_valid
);

	localparam int IDX_W = $clog2(MAX_POINTS);
	localparam int CNT_W = IDX_W + 1;
	localparam int T_W   = T_FRAC_BITS + 1;
	localparam int S_W   = T_W + IDX_W;
	localparam logic [T_W-1:0] ONE = T_W'(1) << T_FRAC_BITS;

	// ---------------------------------------------------------------- config
	logic [CNT_REG_W-1:0] point_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= '0;
		end else if (cfg_we) begin
			point_count_q <= cfg_wdata;
		end
	end

	// ---------------------------------------------------------------- control
	// Whole pipeline moves together; only a full skid register holds it.
	logic en;
	logic skid_valid_q;
	logic rsp_valid_q;
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;
	logic op_s1, op_s2, op_s3;

	assign en        = !skid_valid_q;
	assign cmd_stall = skid_valid_q;

	// ---------------------------------------------------------------- entry
	logic [CNT_W-1:0] n_clamp;
	logic [T_W-1:0]   t_sat;

	always_comb begin
		if (32'(point_count_q) > MAX_POINTS) begin
			n_clamp = CNT_W'(MAX_POINTS);
		end else begin
			n_clamp = CNT_W'(point_count_q);
		end
		t_sat = (t_param > ONE) ? ONE : t_param;
	end

	// s1: registered command
	logic [T_W-1:0]   t_s1;
	logic [IDX_W-1:0] d_s1;
	logic             few_s1;
	logic             wr_ok_s1, wr_ok_s2, wr_ok_s3;
	logic [IDX_W-1:0] waddr_s1, waddr_s2, waddr_s3;
	logic [POINT_W-1:0] wdata_s1, wdata_s2, wdata_s3;

	// s2: t * (count - 1)
	logic [S_W-1:0]   s_s2;
	logic [IDX_W-1:0] d_s2;
	logic             few_s2;

	// s3: segment, fraction, neighbor indices
	logic [IDX_W:0]   idx_raw, idx2;
	logic [IDX_W-1:0] dm1, idx_c, i0_c, i2_c, i3_c;
	logic [T_W-1:0]   frac_c;
	logic [IDX_W-1:0] i0_s3, i1_s3, i2_s3, i3_s3;
	logic [T_W-1:0]   frac_s3;
	logic             few_s3;

	always_comb begin
		idx_raw = s_s2[S_W-1:T_FRAC_BITS];
		dm1     = d_s2 - IDX_W'(1);
		// end of curve: last segment with the fraction at exactly one
		if (idx_raw > {1'b0, dm1}) begin
			idx_c  = dm1;
			frac_c = ONE;
		end else begin
			idx_c  = idx_raw[IDX_W-1:0];
			frac_c = {1'b0, s_s2[T_FRAC_BITS-1:0]};
		end
		i0_c = (idx_c == '0) ? '0 : idx_c - IDX_W'(1);
		i2_c = idx_c + IDX_W'(1);
		idx2 = {1'b0, idx_c} + (IDX_W+1)'(2);
		i3_c = (idx2 > {1'b0, d_s2}) ? d_s2 : idx2[IDX_W-1:0];
	end

	// s4: table words land in the RAM read registers
	logic [POINT_W-1:0] rd_a0, rd_a1, rd_b0, rd_b1;
	logic [T_W-1:0]     u1_s4, u2_s4;
	logic               few_s4;
	logic               ram_we;

	assign ram_we = en && valid_s3 && (op_s3 == OP_WRITE) && wr_ok_s3;

	// copy A serves p0/p1, copy B serves p2/p3
	crse_ram #(.WIDTH(POINT_W), .DEPTH(MAX_POINTS)) u_ram_a (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (waddr_s3),
		.wdata   (wdata_s3),
		.re      (en),
		.raddr_a (i0_s3),
		.raddr_b (i1_s3),
		.rdata_a (rd_a0),
		.rdata_b (rd_a1)
	);

	crse_ram #(.WIDTH(POINT_W), .DEPTH(MAX_POINTS)) u_ram_b (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (waddr_s3),
		.wdata   (wdata_s3),
		.re      (en),
		.raddr_a (i2_s3),
		.raddr_b (i3_s3),
		.rdata_a (rd_b0),
		.rdata_b (rd_b1)
	);

	// s5: powers of u for the blend's product stage
	logic [T_W-1:0] u1_s5, u2_s5, u3_s5;
	logic           few_s5, few_s6, few_s7;
	logic [2*T_W-1:0] uu_prod, u3_prod;

	assign uu_prod = (2*T_W)'(frac_s3) * (2*T_W)'(frac_s3);
	assign u3_prod = (2*T_W)'(u2_s4) * (2*T_W)'(u1_s4);

	// ---------------------------------------------------------------- payload
	always_ff @(posedge clk) begin
		if (en) begin
			t_s1     <= t_sat;
			d_s1     <= IDX_W'(n_clamp - CNT_W'(1));
			few_s1   <= 32'(n_clamp) < MIN_POINTS;
			wr_ok_s1 <= 32'(point_index) < MAX_POINTS;
			waddr_s1 <= IDX_W'(point_index);
			wdata_s1 <= {point_z, point_y, point_x};

			s_s2     <= S_W'(t_s1) * S_W'(d_s1);
			d_s2     <= d_s1;
			few_s2   <= few_s1;
			wr_ok_s2 <= wr_ok_s1;
			waddr_s2 <= waddr_s1;
			wdata_s2 <= wdata_s1;

			i0_s3    <= i0_c;
			i1_s3    <= idx_c;
			i2_s3    <= i2_c;
			i3_s3    <= i3_c;
			frac_s3  <= frac_c;
			few_s3   <= few_s2;
			wr_ok_s3 <= wr_ok_s2;
			waddr_s3 <= waddr_s2;
			wdata_s3 <= wdata_s2;

			u1_s4    <= frac_s3;
			u2_s4    <= T_W'(uu_prod >> T_FRAC_BITS);
			few_s4   <= few_s3;

			u1_s5    <= u1_s4;
			u2_s5    <= u2_s4;
			u3_s5    <= T_W'(u3_prod >> T_FRAC_BITS);
			few_s5   <= few_s4;

			few_s6   <= few_s5;
			few_s7   <= few_s6;
		end
	end

	// ---------------------------------------------------------------- blend
	coord_t sat_x, sat_y, sat_z;

	crse_blend #(.T_FRAC_BITS(T_FRAC_BITS)) u_blend_x (
		.clk (clk), .en (en),
		.p0 (rd_a0[COORD_W-1:0]), .p1 (rd_a1[COORD_W-1:0]),
		.p2 (rd_b0[COORD_W-1:0]), .p3 (rd_b1[COORD_W-1:0]),
		.u1 (u1_s5), .u2 (u2_s5), .u3 (u3_s5),
		.sum_sat (sat_x)
	);

	crse_blend #(.T_FRAC_BITS(T_FRAC_BITS)) u_blend_y (
		.clk (clk), .en (en),
		.p0 (rd_a0[2*COORD_W-1:COORD_W]), .p1 (rd_a1[2*COORD_W-1:COORD_W]),
		.p2 (rd_b0[2*COORD_W-1:COORD_W]), .p3 (rd_b1[2*COORD_W-1:COORD_W]),
		.u1 (u1_s5), .u2 (u2_s5), .u3 (u3_s5),
		.sum_sat (sat_y)
	);

	crse_blend #(.T_FRAC_BITS(T_FRAC_BITS)) u_blend_z (
		.clk (clk), .en (en),
		.p0 (rd_a0[3*COORD_W-1:2*COORD_W]), .p1 (rd_a1[3*COORD_W-1:2*COORD_W]),
		.p2 (rd_b0[3*COORD_W-1:2*COORD_W]), .p3 (rd_b1[3*COORD_W-1:2*COORD_W]),
		.u1 (u1_s5), .u2 (u2_s5), .u3 (u3_s5),
		.sum_sat (sat_z)
	);

	// ---------------------------------------------------------------- output
	res_t res_new, res_q, skid_q;
	logic out_free;

	always_comb begin
		res_new.ok = !few_s7;
		res_new.x  = few_s7 ? '0 : sat_x;
		res_new.y  = few_s7 ? '0 : sat_y;
		res_new.z  = few_s7 ? '0 : sat_z;
	end

	assign out_free = !rsp_valid_q || !rsp_stall;

	// valid bits; write beats drop out after the table stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			valid_s3     <= 1'b0;
			valid_s4     <= 1'b0;
			valid_s5     <= 1'b0;
			valid_s6     <= 1'b0;
			valid_s7     <= 1'b0;
			op_s1        <= OP_WRITE;
			op_s2        <= OP_WRITE;
			op_s3        <= OP_WRITE;
			rsp_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (en) begin
				valid_s1 <= cmd_valid;
				valid_s2 <= valid_s1;
				valid_s3 <= valid_s2;
				valid_s4 <= valid_s3 && (op_s3 == OP_EVAL);
				valid_s5 <= valid_s4;
				valid_s6 <= valid_s5;
				valid_s7 <= valid_s6;
				op_s1    <= opcode;
				op_s2    <= op_s1;
				op_s3    <= op_s2;
			end
			if (out_free) begin
				if (skid_valid_q) begin
					rsp_valid_q  <= 1'b1;
					skid_valid_q <= 1'b0;
				end else begin
					rsp_valid_q <= valid_s7;
				end
			end else if (en && valid_s7) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			res_q <= skid_valid_q ? skid_q : res_new;
		end else if (en && valid_s7) begin
			skid_q <= res_new;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign curve_x      = res_q.x;
	assign curve_y      = res_q.y;
	assign curve_z      = res_q.z;
	assign result_valid = res_q.ok;

endmodule

`default_nettype wire

>>> rtl/crse_ram.sv
// crse_ram: generic RAM, one write port, two registered read ports.
// No dependencies.
`default_nettype none

module crse_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_a,
	output logic      [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

`default_nettype wire

>>> rtl/crse_blend.sv
// crse_blend: one axis of the Catmull-Rom blend, three register stages.
// Depends on crse_pkg for coordinate types and internal widths.
`default_nettype none

module crse_blend
	import crse_pkg::*;
#(
	parameter int T_FRAC_BITS = 16
) (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire coord_t             p0,
	input  wire coord_t             p1,
	input  wire coord_t             p2,
	input  wire coord_t             p3,
	input  wire logic [T_FRAC_BITS:0] u1,
	input  wire logic [T_FRAC_BITS:0] u2,
	input  wire logic [T_FRAC_BITS:0] u3,
	output coord_t                  sum_sat
);

	localparam int PROD_W = COEF_W + T_FRAC_BITS + 2;

	logic signed [COEF_W-1:0] q0, q1, q2, q3;
	logic signed [COEF_W-1:0] a_s5, b_s5, c_s5, e_s5;
	logic signed [COEF_W-1:0] a_s6, tb_s6, tc_s6, te_s6;
	logic signed [PROD_W-1:0] pb, pc, pe;
	logic signed [SUM_W-1:0]  sum_s7, half;

	assign q0 = COEF_W'(p0);
	assign q1 = COEF_W'(p1);
	assign q2 = COEF_W'(p2);
	assign q3 = COEF_W'(p3);

	// u is at most 1.0, so a floor-shifted term never outgrows its coefficient
	assign pb = PROD_W'(b_s5) * PROD_W'($signed({1'b0, u1}));
	assign pc = PROD_W'(c_s5) * PROD_W'($signed({1'b0, u2}));
	assign pe = PROD_W'(e_s5) * PROD_W'($signed({1'b0, u3}));

	always_ff @(posedge clk) begin
		if (en) begin
			a_s5   <= q1 <<< 1;
			b_s5   <= q2 - q0;
			c_s5   <= (q0 <<< 1) - ((q1 <<< 2) + q1) + (q2 <<< 2) - q3;
			e_s5   <= ((q1 <<< 1) + q1) - ((q2 <<< 1) + q2) + q3 - q0;
			a_s6   <= a_s5;
			tb_s6  <= COEF_W'(pb >>> T_FRAC_BITS);
			tc_s6  <= COEF_W'(pc >>> T_FRAC_BITS);
			te_s6  <= COEF_W'(pe >>> T_FRAC_BITS);
			sum_s7 <= SUM_W'(a_s6) + SUM_W'(tb_s6) + SUM_W'(tc_s6) + SUM_W'(te_s6);
		end
	end

	assign half = sum_s7 >>> 1;

	always_comb begin
		if (half[SUM_W-1:COORD_W-1] == '0 || half[SUM_W-1:COORD_W-1] == '1) begin
			sum_sat = half[COORD_W-1:0];
		end else if (half[SUM_W-1]) begin
			sum_sat = COORD_MIN;
		end else begin
			sum_sat = COORD_MAX;
		end
	end

endmodule

`default_nettype wire
